FILE: sv/pba_pkg.sv
// Shared types and constants of the paged bump allocator.
package pba_pkg;

   localparam int SIZE_W   = 16;
   localparam int HEADER_W = 8;
   localparam int PAGE_W   = 4;
   localparam int CSR_IW   = 1;

   localparam logic [SIZE_W-1:0]   PAGE_BYTES_RESET   = 16'd256;
   localparam logic [HEADER_W-1:0] HEADER_BYTES_RESET = 8'd24;

   localparam logic [CSR_IW-1:0] CSR_PAGE_BYTES   = 1'b0;
   localparam logic [CSR_IW-1:0] CSR_HEADER_BYTES = 1'b1;

   localparam logic MODE_ALLOC      = 1'b0;
   localparam logic MODE_POOL_RESET = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERSIZE = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_RESET    = 2'd3
   } status_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   page_bytes;
      logic [HEADER_W-1:0] header_bytes;
   } cfg_type;

   typedef struct packed {
      logic              granted;
      logic [PAGE_W-1:0] page_index;
      logic [SIZE_W-1:0] byte_offset;
      status_type        status;
   } result_type;

endpackage

FILE: sv/pba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/pba_search.sv
// Page fill memory, newest-to-oldest first-fit search and page opening.
module pba_search #(
   parameter int MAX_PAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pba_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [pba_pkg::SIZE_W-1:0]    req_request_size,
   output logic                          res_valid,
   input  logic                          res_take,
   output pba_pkg::result_type           res
);
   import pba_pkg::*;

   localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int PW = $clog2(MAX_PAGES + 1);

   typedef enum logic [3:0] {
      ST_INIT   = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [PW-1:0]     pages_open_ff, pages_open_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   result_type        res_ff, res_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [SIZE_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [SIZE_W-1:0] rd_data;

   logic [SIZE_W-1:0] header_ext;
   logic [SIZE_W-1:0] usable;
   logic [SIZE_W-1:0] remaining;
   logic [PW-1:0]     pages_last;
   logic [AW+3:0]     cur_ext;
   logic [PW+3:0]     open_ext;

   pba_ram #(
      .WIDTH (SIZE_W),
      .DEPTH (MAX_PAGES)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign header_ext = {{(SIZE_W-HEADER_W){1'b0}}, cfg.header_bytes};
   assign usable     = (cfg.page_bytes > header_ext) ? cfg.page_bytes - header_ext : '0;
   assign remaining  = (cfg.page_bytes > rd_data) ? cfg.page_bytes - rd_data : '0;
   assign pages_last = pages_open_ff - PW'(1);
   assign cur_ext    = {4'b0000, cur_ff};
   assign open_ext   = {4'b0000, pages_open_ff};

   always_comb begin
      state_in      = state_ff;
      pages_open_in = pages_open_ff;
      cur_in        = cur_ff;
      size_in       = size_ff;
      res_in        = res_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = header_ext;
      rd_addr       = cur_ff - AW'(1);
      case (state_ff)
         ST_INIT: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            rd_addr = pages_last[AW-1:0];
            if (req_valid) begin
               size_in = req_request_size;
               res_in  = '{granted: 1'b0, page_index: '0, byte_offset: '0,
                           status: STATUS_OK};
               if (req_mode == MODE_POOL_RESET) begin
                  wr_en         = 1'b1;
                  pages_open_in = PW'(1);
                  res_in.status = STATUS_RESET;
                  state_in      = ST_DONE;
               end else if (req_request_size > usable) begin
                  res_in.status = STATUS_OVERSIZE;
                  state_in      = ST_DONE;
               end else begin
                  cur_in   = pages_last[AW-1:0];
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (size_ff <= remaining) begin
               wr_en              = 1'b1;
               wr_addr            = cur_ff;
               wr_data            = rd_data + size_ff;
               res_in.granted     = 1'b1;
               res_in.page_index  = cur_ext[3:0];
               res_in.byte_offset = rd_data;
               state_in           = ST_DONE;
            end else if (cur_ff == '0) begin
               if (pages_open_ff == PW'(MAX_PAGES)) begin
                  res_in.status = STATUS_FULL;
               end else begin
                  wr_en              = 1'b1;
                  wr_addr            = pages_open_ff[AW-1:0];
                  wr_data            = header_ext + size_ff;
                  pages_open_in      = pages_open_ff + PW'(1);
                  res_in.granted     = 1'b1;
                  res_in.page_index  = open_ext[3:0];
                  res_in.byte_offset = header_ext;
               end
               state_in = ST_DONE;
            end else begin
               cur_in = cur_ff - AW'(1);
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         pages_open_ff <= PW'(1);
      end else begin
         state_ff      <= state_in;
         pages_open_ff <= pages_open_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      size_ff <= size_in;
      res_ff  <= res_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

endmodule

FILE: sv/paged_bump_allocator_top.sv
// Paged bump allocator: configuration registers, search engine and result register.
//
// An allocation searches the open pages from the newest to the oldest, one
// page fill read from the fill RAM per cycle, and takes the first page with
// room; when none fits it opens a new page. The search visits from 1 up to
// the number of open pages (at most MAX_PAGES), and a new request is taken
// only after the result of the last one has gone into the result register.
// A pool reset or an oversized request skips the search. After reset the
// block writes the fill of page 0 before it accepts a beat. The result register
// lets the next request beat be taken while a result beat still waits.
module paged_bump_allocator_top #(
   parameter int MAX_PAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_request_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_granted,
   output logic [3:0]  rsp_page_index,
   output logic [15:0] rsp_byte_offset,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);
   import pba_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   result_type res;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       res_valid;
   logic       res_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PAGE_BYTES:   cfg_in.page_bytes   = csr_data;
            CSR_HEADER_BYTES: cfg_in.header_bytes = csr_data[HEADER_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   pba_search #(
      .MAX_PAGES (MAX_PAGES)
   ) u_search (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_request_size (req_request_size),
      .res_valid        (res_valid),
      .res_take         (res_take),
      .res              (res)
   );

   assign res_take     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_valid ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_in       = (res_valid && res_take) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_bytes   <= PAGE_BYTES_RESET;
         cfg_ff.header_bytes <= HEADER_BYTES_RESET;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_ff.granted;
   assign rsp_page_index  = rsp_ff.page_index;
   assign rsp_byte_offset = rsp_ff.byte_offset;
   assign rsp_status      = rsp_ff.status;

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_page_index == '0 && rsp_byte_offset == '0)
      else $error("refused result beat carries a nonzero page or offset");

   a_grant_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_granted == (rsp_status == STATUS_OK)))
      else $error("granted flag disagrees with status");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous request still in flight");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the paged bump allocator: directed and random requests with a scoreboard.
`timescale 1ns / 100ps

module testbench;
   import pba_pkg::*;

   localparam int POOL_PAGES  = 16;
   localparam int QUIET_LIMIT = 3000;

   class grant_scoreboard;
      logic [SIZE_W-1:0]   page_bytes;
      logic [HEADER_W-1:0] header_bytes;
      int unsigned         pages_open;
      logic [SIZE_W-1:0]   page_fill [POOL_PAGES];
      result_type          expected_grants [$];
      int                  errors;
      int                  checked;
      int                  grants;
      int                  oversized;
      int                  pool_full;
      int                  pool_resets;

      function new();
         page_bytes   = PAGE_BYTES_RESET;
         header_bytes = HEADER_BYTES_RESET;
         errors       = 0;
         checked      = 0;
         grants       = 0;
         oversized    = 0;
         pool_full    = 0;
         pool_resets  = 0;
         open_pool();
      endfunction

      function void open_pool();
         page_fill[0] = {{(SIZE_W-HEADER_W){1'b0}}, header_bytes};
         pages_open   = 1;
      endfunction

      function int unsigned room(logic [SIZE_W-1:0] fill);
         return (page_bytes > fill) ? page_bytes - fill : 0;
      endfunction

      function void write_reg(logic [CSR_IW-1:0] index, logic [SIZE_W-1:0] data);
         if (index == CSR_PAGE_BYTES) begin
            page_bytes = data;
         end else if (index == CSR_HEADER_BYTES) begin
            header_bytes = data[HEADER_W-1:0];
         end
      endfunction

      function void note_request(logic mode, logic [SIZE_W-1:0] size);
         result_type  grant;
         int unsigned usable;
         int          hit;
         grant        = '0;
         grant.status = STATUS_OK;
         hit          = -1;
         if (mode == MODE_POOL_RESET) begin
            open_pool();
            grant.status = STATUS_RESET;
            pool_resets++;
         end else begin
            usable = room({{(SIZE_W-HEADER_W){1'b0}}, header_bytes});
            if (size > usable) begin
               grant.status = STATUS_OVERSIZE;
               oversized++;
            end else begin
               for (int p = int'(pages_open) - 1; p >= 0; p--) begin
                  if (hit < 0 && size <= room(page_fill[p])) hit = p;
               end
               if (hit < 0) begin
                  if (pages_open >= POOL_PAGES) begin
                     grant.status = STATUS_FULL;
                     pool_full++;
                  end else begin
                     hit = int'(pages_open);
                     page_fill[hit] = {{(SIZE_W-HEADER_W){1'b0}}, header_bytes};
                     pages_open++;
                  end
               end
               if (hit >= 0) begin
                  grant.granted     = 1'b1;
                  grant.page_index  = hit[PAGE_W-1:0];
                  grant.byte_offset = page_fill[hit];
                  page_fill[hit]    = page_fill[hit] + size;
                  grants++;
               end
            end
         end
         expected_grants.push_back(grant);
      endfunction

      function void check_grant(result_type got);
         result_type want;
         if (expected_grants.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected result beat: granted=%0d page=%0d offset=%0d status=%0d",
                        got.granted, got.page_index, got.byte_offset, got.status);
            end
            return;
         end
         want = expected_grants.pop_front();
         checked++;
         if (got.granted != want.granted || got.page_index != want.page_index ||
             got.byte_offset != want.byte_offset || got.status != want.status) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch on result %0d: expected granted=%0d page=%0d offset=%0d status=%0d",
                        checked, want.granted, want.page_index, want.byte_offset, want.status);
               $display("                       actual   granted=%0d page=%0d offset=%0d status=%0d",
                        got.granted, got.page_index, got.byte_offset, got.status);
            end
         end
      endfunction

      function int outstanding();
         return expected_grants.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_mode;
   logic [15:0]       req_request_size;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_granted;
   logic [3:0]        rsp_page_index;
   logic [15:0]       rsp_byte_offset;
   logic [1:0]        rsp_status;
   logic              csr_valid;
   logic              csr_ready;
   logic [0:0]        csr_index;
   logic [15:0]       csr_data;

   grant_scoreboard   sb;
   cfg_type           current_cfg;
   int                req_idle_pct;
   int                rsp_idle_pct;
   int                hold_off_cycles;
   int                quiet_cycles;
   int                settings_used;

   paged_bump_allocator_top #(
      .MAX_PAGES(POOL_PAGES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_request_size(req_request_size),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_granted     (rsp_granted),
      .rsp_page_index  (rsp_page_index),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : beat_monitor
      result_type got;
      logic       moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            sb.note_request(req_mode, req_request_size);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            got.granted     = rsp_granted;
            got.page_index  = rsp_page_index;
            got.byte_offset = rsp_byte_offset;
            got.status      = status_type'(rsp_status);
            sb.check_grant(got);
            moved = 1'b1;
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      do @(negedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("no beat moved for %0d cycles", QUIET_LIMIT);
      $display("paged_bump_allocator_top test failed");
      $finish;
   end

   task automatic send_item(input logic mode, input logic [15:0] size);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_request_size <= size;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_pool_idle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [0:0] index, input logic [15:0] data);
      wait_pool_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] page_bytes, input logic [7:0] header_bytes);
      write_csr(CSR_PAGE_BYTES, page_bytes);
      write_csr(CSR_HEADER_BYTES, {8'd0, header_bytes});
      current_cfg.page_bytes   = page_bytes;
      current_cfg.header_bytes = header_bytes;
      settings_used++;
   endtask

   task automatic run_random(input int count);
      int unsigned usable;
      int unsigned pick;
      logic        mode;
      logic [15:0] size;
      repeat (count) begin
         usable = (current_cfg.page_bytes > current_cfg.header_bytes) ?
                  current_cfg.page_bytes - current_cfg.header_bytes : 0;
         pick = $urandom_range(99);
         mode = MODE_ALLOC;
         if (pick < 2) begin
            mode = MODE_POOL_RESET;
            size = 16'($urandom);
         end else if (pick < 12) begin
            size = 16'd0;
         end else if (pick < 22) begin
            size = 16'(usable);
         end else if (pick < 29) begin
            size = (usable < 65535) ? 16'($urandom_range(65535, usable + 1)) : 16'hFFFF;
         end else if (pick < 35) begin
            size = 16'($urandom);
         end else begin
            size = 16'($urandom_range(usable / 3));
         end
         send_item(mode, size);
      end
   endtask

   initial begin
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_ALLOC;
      req_request_size = 16'd0;
      csr_valid        = 1'b0;
      csr_index        = CSR_PAGE_BYTES;
      csr_data         = 16'd0;
      quiet_cycles     = 0;
      hold_off_cycles  = 0;
      settings_used    = 1;
      req_idle_pct     = 22;
      rsp_idle_pct     = 61;
      current_cfg.page_bytes   = PAGE_BYTES_RESET;
      current_cfg.header_bytes = HEADER_BYTES_RESET;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests under the reset configuration.
      send_item(MODE_ALLOC, 16'd0);
      send_item(MODE_ALLOC, 16'd232);
      send_item(MODE_ALLOC, 16'd233);
      send_item(MODE_ALLOC, 16'hFFFF);
      send_item(MODE_ALLOC, 16'd1);
      send_item(MODE_ALLOC, 16'd100);
      send_item(MODE_POOL_RESET, 16'hFFFF);
      repeat (POOL_PAGES) send_item(MODE_ALLOC, 16'd232);
      send_item(MODE_ALLOC, 16'd1);
      send_item(MODE_ALLOC, 16'd0);
      send_item(MODE_POOL_RESET, 16'd0);
      run_random(80);

      configure(16'd1, 8'd0);
      run_random(40);
      configure(16'hFFFF, 8'd0);
      run_random(60);
      configure(16'd100, 8'd255);
      run_random(30);

      req_idle_pct = 61;
      rsp_idle_pct = 22;
      configure(16'hFFFF, 8'd255);
      run_random(60);
      // Open pages keep fills far beyond the smaller page size.
      configure(16'd300, 8'd8);
      run_random(80);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      configure(16'd512, 8'd100);
      hold_off_cycles = 80;
      run_random(80);
      configure(PAGE_BYTES_RESET, HEADER_BYTES_RESET);
      run_random(40);
      wait_pool_idle();
      run_random(40);

      wait_pool_idle();
      repeat (40) @(negedge clock);
      $display("Checked %0d results over %0d register settings: %0d grants, %0d oversized,",
               sb.checked, settings_used, sb.grants, sb.oversized);
      $display("%0d pool-full refusals, %0d pool resets, %0d failures.",
               sb.pool_full, sb.pool_resets, sb.errors + sb.outstanding());
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("paged_bump_allocator_top test passed");
      end else begin
         $display("paged_bump_allocator_top test failed");
      end
      $finish;
   end

endmodule
